### hw/rtl/fru_field_decoder_defines.svh
// Assertion macros shared by the field decoder RTL.
// Define ASSERT_OFF to compile the checks out; needs clk and rst_n in scope.
`ifndef FRU_FIELD_DECODER_DEFINES_SVH
`define FRU_FIELD_DECODER_DEFINES_SVH

`ifndef ASSERT_OFF
`define FRUFD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
`define FRUFD_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);
`else
`define FRUFD_ASSERT(lbl, prop, msg)
`define FRUFD_NEVER(lbl, expr, msg)
`endif

`endif

### hw/rtl/frufd_pkg.sv
// Package of the FRU field decoder: types, codes and character tables.
// No dependencies; used by every module of the block.
package frufd_pkg;

    localparam int unsigned POS_W     = 11;
    localparam int unsigned OFFSET_W  = 8;
    localparam int unsigned LEN_W     = 6;
    localparam int unsigned GRP_W     = 16;
    localparam int unsigned GCNT_W    = 2;
    localparam int unsigned BURST_MAX = 4;
    localparam int unsigned CNT_W     = 3;
    localparam int unsigned IDX_W     = 2;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 11;

    localparam logic [POS_W-1:0] POS_MAX     = '1;
    localparam logic [7:0]       END_MARK    = 8'hC1;
    localparam logic [7:0]       ASCII6_BIAS = 8'h20;

    localparam logic [CFG_IDX_W-1:0] CFG_FIELDS_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AREA_LENGTH   = 2'd1;

    localparam logic [OFFSET_W-1:0] FIELDS_OFFSET_RST = 8'd3;
    localparam logic [POS_W-1:0]    AREA_LENGTH_RST   = '0;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_TL   = 2'd1,
        MODE_DATA = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        FMT_BIN    = 2'd0,
        FMT_BCD    = 2'd1,
        FMT_ASCII6 = 2'd2,
        FMT_ASCII8 = 2'd3
    } fmt_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] fields_offset;
        logic [POS_W-1:0]    area_length;
    } cfg_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       field_done;
        logic       fields_end;
    } res_t;

    typedef struct packed {
        res_t [BURST_MAX-1:0] items;
        logic [CNT_W-1:0]     cnt;
    } burst_t;

    localparam logic [7:0] BCD_TABLE [16] = '{
        "0", "1", "2", "3", "4", "5", "6", "7",
        "8", "9", " ", "-", ".", ":", ",", "_"
    };

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < 4'd10) begin
            ch = 8'h30 + {4'h0, nib};
        end else begin
            ch = 8'h57 + {4'h0, nib};
        end
        return ch;
    endfunction

    function automatic res_t make_res(input logic [7:0] ch, input logic valid,
                                      input logic done, input logic fend);
        res_t r;
        r.out_char   = valid ? ch : 8'h00;
        r.char_valid = valid;
        r.field_done = done;
        r.fields_end = fend;
        return r;
    endfunction

endpackage

### hw/rtl/frufd_parse.sv
// Input register and field parser of the FRU field decoder.
// Depends on frufd_pkg and fru_field_decoder_defines.svh.
`include "fru_field_decoder_defines.svh"

module frufd_parse (
    input  logic                 clk,
    input  logic                 rst_n,
    input  frufd_pkg::cfg_t      cfg,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           in_byte,
    input  logic                 area_start,
    output logic                 load,
    output frufd_pkg::burst_t    burst,
    input  logic                 can_load
);
    import frufd_pkg::*;

    logic               in_full_reg, in_full_next;
    logic [7:0]         byte_reg;
    logic               start_reg;

    mode_t              mode_reg, mode_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    fmt_t               kind_reg, kind_next;
    logic [LEN_W-1:0]   left_reg, left_next;
    logic [GRP_W-1:0]   grp_reg, grp_next;
    logic [GCNT_W-1:0]  gcnt_reg, gcnt_next;

    logic               accept;
    logic               consume;

    assign consume      = in_full_reg && ((burst.cnt == '0) || can_load);
    assign load         = consume && (burst.cnt != '0);
    assign in_stall     = in_full_reg && !consume;
    assign accept       = in_valid && !in_stall;
    assign in_full_next = accept ? 1'b1 : (consume ? 1'b0 : in_full_reg);

    always_comb
    begin
        mode_t             cur_mode;
        logic [POS_W-1:0]  p;
        logic [LEN_W-1:0]  left_dec;
        logic              fin;
        logic [4:0]        sh;
        logic [23:0]       grp_v;

        mode_next = mode_reg;
        pos_next  = pos_reg;
        kind_next = kind_reg;
        left_next = left_reg;
        grp_next  = grp_reg;
        gcnt_next = gcnt_reg;
        burst     = '0;

        cur_mode = mode_reg;
        p        = pos_reg;
        if (start_reg)
        begin
            cur_mode  = MODE_TL;
            p         = '0;
            kind_next = FMT_BIN;
            left_next = '0;
            grp_next  = '0;
            gcnt_next = '0;
            mode_next = MODE_TL;
        end

        left_dec = left_reg - 1'b1;
        fin      = (left_dec == '0);
        sh       = gcnt_reg[1] ? 5'd16 : {1'b0, gcnt_reg[0], 3'b000};
        grp_v    = {8'h00, grp_reg} | ({16'h0000, byte_reg} << sh);

        if (cur_mode == MODE_TL || cur_mode == MODE_DATA)
        begin
            pos_next = (p == POS_MAX) ? p : p + 1'b1;
            if (cur_mode == MODE_TL)
            begin
                if (p < {3'b000, cfg.fields_offset})
                begin
                    // still in the area header: drop the byte
                end
                else if (p >= cfg.area_length || byte_reg == END_MARK)
                begin
                    burst.items[0] = make_res(8'h00, 1'b0, 1'b0, 1'b1);
                    burst.cnt      = 3'd1;
                    mode_next      = MODE_IDLE;
                end
                else if (byte_reg[5:0] == '0)
                begin
                    burst.items[0] = make_res(8'h00, 1'b0, 1'b1, 1'b0);
                    burst.cnt      = 3'd1;
                end
                else
                begin
                    kind_next = fmt_t'(byte_reg[7:6]);
                    left_next = byte_reg[5:0];
                    grp_next  = '0;
                    gcnt_next = '0;
                    mode_next = MODE_DATA;
                end
            end
            else
            begin
                left_next = left_dec;
                case (kind_reg)
                    FMT_BIN:
                    begin
                        burst.items[0] = make_res(hex_char(byte_reg[7:4]), 1'b1, 1'b0, 1'b0);
                        burst.items[1] = make_res(hex_char(byte_reg[3:0]), 1'b1, fin, 1'b0);
                        burst.cnt      = 3'd2;
                    end
                    FMT_BCD:
                    begin
                        burst.items[0] = make_res(BCD_TABLE[byte_reg[7:4]], 1'b1, 1'b0, 1'b0);
                        burst.items[1] = make_res(BCD_TABLE[byte_reg[3:0]], 1'b1, fin, 1'b0);
                        burst.cnt      = 3'd2;
                    end
                    FMT_ASCII6:
                    begin
                        if (gcnt_reg[1] || fin)
                        begin
                            for (int k = 0; k < BURST_MAX; k++)
                            begin
                                burst.items[k] = make_res(
                                    {2'b00, grp_v[6*k +: 6]} + ASCII6_BIAS, 1'b1,
                                    (k == BURST_MAX - 1) ? fin : 1'b0, 1'b0);
                            end
                            burst.cnt = 3'd4;
                            grp_next  = '0;
                            gcnt_next = '0;
                        end
                        else
                        begin
                            grp_next  = grp_reg | ({8'h00, byte_reg} << {gcnt_reg[0], 3'b000});
                            gcnt_next = gcnt_reg + 1'b1;
                        end
                    end
                    default:
                    begin
                        burst.items[0] = make_res(byte_reg, 1'b1, fin, 1'b0);
                        burst.cnt      = 3'd1;
                    end
                endcase
                if (fin)
                begin
                    mode_next = MODE_TL;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
            mode_reg    <= MODE_IDLE;
            pos_reg     <= '0;
            kind_reg    <= FMT_BIN;
            left_reg    <= '0;
            grp_reg     <= '0;
            gcnt_reg    <= '0;
        end
        else
        begin
            in_full_reg <= in_full_next;
            if (consume)
            begin
                mode_reg <= mode_next;
                pos_reg  <= pos_next;
                kind_reg <= kind_next;
                left_reg <= left_next;
                grp_reg  <= grp_next;
                gcnt_reg <= gcnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg  <= in_byte;
            start_reg <= area_start;
        end
    end

    `FRUFD_NEVER(a_load_empty, load && burst.cnt == '0, "burst loaded with no results")
    `FRUFD_ASSERT(a_end_idles, load && burst.items[0].fields_end |=> mode_reg == MODE_IDLE, "field list end did not idle the parser")
    `FRUFD_NEVER(a_data_no_left, mode_reg == MODE_DATA && left_reg == '0, "data mode with no bytes left")

endmodule

### hw/rtl/frufd_emit.sv
// Result register of the FRU field decoder: plays out one burst, one result a cycle
// while out_stall is low. Depends on frufd_pkg and fru_field_decoder_defines.svh.
`include "fru_field_decoder_defines.svh"

module frufd_emit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  frufd_pkg::burst_t    burst,
    output logic                 can_load,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           out_char,
    output logic                 char_valid,
    output logic                 field_done,
    output logic                 fields_end,
    output logic                 last
);
    import frufd_pkg::*;

    burst_t             burst_reg;
    logic               valid_reg, valid_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               fire;
    logic               at_last;
    res_t               cur;

    assign cur      = burst_reg.items[idx_reg];
    assign at_last  = (({1'b0, idx_reg} + 1'b1) == burst_reg.cnt);
    assign fire     = valid_reg && !out_stall;
    assign can_load = !valid_reg || (fire && at_last);

    assign out_valid  = valid_reg;
    assign out_char   = cur.out_char;
    assign char_valid = cur.char_valid;
    assign field_done = cur.field_done;
    assign fields_end = cur.fields_end;
    assign last       = at_last;

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = '0;
        end
        else if (fire)
        begin
            if (at_last)
            begin
                valid_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            burst_reg <= burst;
        end
    end

    `FRUFD_ASSERT(a_idx_range, valid_reg |-> {1'b0, idx_reg} < burst_reg.cnt, "result index past burst count")
    `FRUFD_ASSERT(a_load_free, load |-> can_load, "burst loaded over unsent results")
    `FRUFD_ASSERT(a_end_marker, valid_reg && fields_end |-> !char_valid && !field_done && last, "malformed end-of-fields marker")

endmodule

### hw/rtl/fru_field_decoder.sv
// Top level of the FRU field decoder: configuration registers, parser and result stage.
// Depends on frufd_pkg, frufd_parse and frufd_emit.
//
//  Channel   Direction  Handshake              Payload
//  -------   ---------  ---------------------  -----------------------------------------
//  input     in         in_valid / in_stall    in_byte, area_start
//  result    out        out_valid / out_stall  out_char, char_valid, field_done,
//                                              fields_end, last
//  config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An accepted byte is held in the input register, is decoded by the parser in one
// pass, and its zero to four results land in the result register together.
// The result register plays out one result per cycle while out_stall is low; a byte makes
// one result for 8-bit ASCII and markers, two for hex and BCD, and four per 6-bit group;
// bytes with no result pass at one per cycle.
// A new byte is taken while results wait; the input register stalls only when it holds a
// byte with results while the result register is busy and does not hand off its final
// result in that cycle.
// Reset idles the parser until an area start and loads fields_offset 3, area_length 0.
// Configuration writes are always ready and take effect on the next byte.

module fru_field_decoder (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [7:0]                        in_byte,
    input  logic                              area_start,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [7:0]                        out_char,
    output logic                              char_valid,
    output logic                              field_done,
    output logic                              fields_end,
    output logic                              last,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [frufd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [frufd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import frufd_pkg::*;

    cfg_t    cfg_reg;
    logic    load;
    logic    can_load;
    burst_t  burst;

    assign cfg_ready = 1'b1;

    // Register writes; indexes past the list drop the transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fields_offset <= FIELDS_OFFSET_RST;
            cfg_reg.area_length   <= AREA_LENGTH_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_FIELDS_OFFSET)
            begin
                cfg_reg.fields_offset <= cfg_data[OFFSET_W-1:0];
            end
            else if (cfg_index == CFG_AREA_LENGTH)
            begin
                cfg_reg.area_length <= cfg_data[POS_W-1:0];
            end
        end
    end

    // Parse: hold one byte, decode it against the field state, hand over its burst.
    frufd_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .area_start (area_start),
        .load       (load),
        .burst      (burst),
        .can_load   (can_load)
    );

    // Emit: advance through the burst one result per transaction, flag the final one.
    frufd_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .burst      (burst),
        .can_load   (can_load),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_char   (out_char),
        .char_valid (char_valid),
        .field_done (field_done),
        .fields_end (fields_end),
        .last       (last)
    );

endmodule

### sim/fru_field_decoder_tb.sv
// Self-checking testbench of fru_field_decoder: a directed table, then random inventory areas.
// Depends on frufd_pkg and the fru_field_decoder RTL; every result is checked by a local predictor.

module fru_field_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import frufd_pkg::*;

    // Clock period is 12 ns, so the pause before a register write and the tail
    // at the end are counted in clock cycles, not in nanoseconds.
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 16;
    localparam int MAX_REPORTS   = 10;
    localparam int PHASE_ITEMS   = 25;

    // Index with no register behind it; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

    localparam string BCD_GLYPHS = "0123456789 -.:,_";

    // One decoded character or marker, as it leaves the result port.
    typedef struct packed {
        logic [7:0] ch;
        logic       valid;
        logic       done;
        logic       fend;
        logic       last;
    } char_rec_t;

    // How a row of the directed table is checked, or that it is a register write.
    typedef enum logic [2:0] {
        ROW_CFG,
        ROW_QUIET,
        ROW_EMPTY,
        ROW_END,
        ROW_CALC
    } row_kind_t;

    typedef struct {
        row_kind_t                kind;
        logic                     start;
        logic [CFG_IDX_W-1:0]     idx;
        logic [CFG_DATA_W-1:0]    val;
    } plan_row_t;

    localparam int PLAN_ROWS = 30;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [7:0]             in_byte;
    logic                   area_start;
    logic                   out_valid;
    logic                   out_stall;
    logic [7:0]             out_char;
    logic                   char_valid;
    logic                   field_done;
    logic                   fields_end;
    logic                   last;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Predictor copy of the registers and of the parse state.
    logic [OFFSET_W-1:0]    reg_offset;
    logic [POS_W-1:0]       reg_alen;
    mode_t                  st_mode;
    logic [POS_W-1:0]       st_pos;
    fmt_t                   st_kind;
    logic [LEN_W-1:0]       st_left;
    logic [GRP_W-1:0]       st_grp;
    logic [GCNT_W-1:0]      st_gcnt;

    char_rec_t              fresh_chars[$];
    char_rec_t              chars_due[$];
    int                     mismatches = 0;
    int                     sent_items = 0;
    bit                     in_steady  = 1'b0;
    bit                     out_steady = 1'b0;

    // Directed table: reset registers first, then every format, empty fields,
    // 6-bit groups full and short and a restart inside a field; plan_tail adds the end marker.
    plan_row_t plan [PLAN_ROWS] = '{
        '{ROW_QUIET, 1'b0, CFG_FIELDS_OFFSET, 11'h05A},  // no area open yet
        '{ROW_QUIET, 1'b1, CFG_FIELDS_OFFSET, 11'h0C1},  // position 0 lies before the offset
        '{ROW_QUIET, 1'b0, CFG_FIELDS_OFFSET, 11'h000},
        '{ROW_QUIET, 1'b0, CFG_FIELDS_OFFSET, 11'h0FF},
        '{ROW_END,   1'b0, CFG_FIELDS_OFFSET, 11'h012},  // area length 0 ends the list
        '{ROW_QUIET, 1'b0, CFG_FIELDS_OFFSET, 11'h037},  // ignored after the end
        '{ROW_CFG,   1'b0, CFG_FIELDS_OFFSET, 11'd1},
        '{ROW_CFG,   1'b0, CFG_AREA_LENGTH,   11'd60},
        '{ROW_CFG,   1'b0, CFG_IDX_SPARE,     11'h7FF},
        '{ROW_QUIET, 1'b1, CFG_FIELDS_OFFSET, 11'h0FF},
        '{ROW_EMPTY, 1'b0, CFG_FIELDS_OFFSET, 11'h000},  // empty binary field
        '{ROW_QUIET, 1'b0, CFG_FIELDS_OFFSET, 11'h002},
        '{ROW_CALC,  1'b0, CFG_FIELDS_OFFSET, 11'h000},
        '{ROW_CALC,  1'b0, CFG_FIELDS_OFFSET, 11'h0FF},
        '{ROW_EMPTY, 1'b0, CFG_FIELDS_OFFSET, 11'h040},  // empty BCD field
        '{ROW_QUIET, 1'b0, CFG_FIELDS_OFFSET, 11'h041},
        '{ROW_CALC,  1'b0, CFG_FIELDS_OFFSET, 11'h0AF},
        '{ROW_EMPTY, 1'b0, CFG_FIELDS_OFFSET, 11'h080},  // empty 6-bit field
        '{ROW_QUIET, 1'b0, CFG_FIELDS_OFFSET, 11'h084},
        '{ROW_CALC,  1'b0, CFG_FIELDS_OFFSET, 11'h0FF},
        '{ROW_CALC,  1'b0, CFG_FIELDS_OFFSET, 11'h0FF},
        '{ROW_CALC,  1'b0, CFG_FIELDS_OFFSET, 11'h0FF},  // full group of three
        '{ROW_CALC,  1'b0, CFG_FIELDS_OFFSET, 11'h001},  // short group, zero padded
        '{ROW_EMPTY, 1'b0, CFG_FIELDS_OFFSET, 11'h0C0},  // empty 8-bit field
        '{ROW_QUIET, 1'b0, CFG_FIELDS_OFFSET, 11'h0C2},
        '{ROW_CALC,  1'b0, CFG_FIELDS_OFFSET, 11'h000},
        '{ROW_CALC,  1'b0, CFG_FIELDS_OFFSET, 11'h0FF},
        '{ROW_QUIET, 1'b0, CFG_FIELDS_OFFSET, 11'h042},
        '{ROW_CALC,  1'b0, CFG_FIELDS_OFFSET, 11'h099},
        '{ROW_QUIET, 1'b1, CFG_FIELDS_OFFSET, 11'h012}   // restart inside the BCD field
    };

    // Rows appended after the restart: the end marker and one ignored byte.
    plan_row_t plan_tail [2] = '{
        '{ROW_END,   1'b0, CFG_FIELDS_OFFSET, 11'h0C1},
        '{ROW_QUIET, 1'b0, CFG_FIELDS_OFFSET, 11'h055}
    };

    fru_field_decoder uut (.*);

    always #6 clk = ~clk;

    // Mostly short gaps, a few long ones; none at all while the side runs steady.
    function automatic int idle_len(input bit steady);
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        return (nib < 4'd10) ? 8'h30 + 8'(nib) : 8'h61 + 8'(nib) - 8'd10;
    endfunction

    function automatic void add_char(input logic [7:0] ch, input logic valid,
                                     input logic done, input logic fend);
        char_rec_t r;
        r.ch    = valid ? ch : 8'h00;
        r.valid = valid;
        r.done  = done;
        r.fend  = fend;
        r.last  = 1'b0;
        fresh_chars.push_back(r);
    endfunction

    // Decode one accepted byte into fresh_chars and advance the parse state.
    task automatic decode_byte(input logic start, input logic [7:0] b);
        logic [POS_W-1:0] p;
        logic             fin;
        logic [23:0]      grp_word;
        int               sh;
        char_rec_t        r;
        fresh_chars.delete();
        if (start) begin
            st_mode = MODE_TL;
            st_pos  = '0;
            st_kind = FMT_BIN;
            st_left = '0;
            st_grp  = '0;
            st_gcnt = '0;
        end else if (st_mode != MODE_TL && st_mode != MODE_DATA) begin
            return;
        end
        p = st_pos;
        if (st_pos != POS_MAX) st_pos = st_pos + 1'b1;

        if (st_mode == MODE_TL) begin
            if (p < POS_W'(reg_offset)) return;
            // Length test wins over the end marker.
            if (p >= reg_alen || b == END_MARK) begin
                add_char(8'h00, 1'b0, 1'b0, 1'b1);
                st_mode = MODE_IDLE;
            end else if (b[5:0] == '0) begin
                add_char(8'h00, 1'b0, 1'b1, 1'b0);
            end else begin
                st_kind = fmt_t'(b[7:6]);
                st_left = b[5:0];
                st_grp  = '0;
                st_gcnt = '0;
                st_mode = MODE_DATA;
            end
        end else begin
            st_left = st_left - 1'b1;
            fin = (st_left == '0);
            case (st_kind)
                FMT_BIN:
                begin
                    add_char(hex_digit(b[7:4]), 1'b1, 1'b0, 1'b0);
                    add_char(hex_digit(b[3:0]), 1'b1, fin, 1'b0);
                end
                FMT_BCD:
                begin
                    add_char(BCD_GLYPHS[b[7:4]], 1'b1, 1'b0, 1'b0);
                    add_char(BCD_GLYPHS[b[3:0]], 1'b1, fin, 1'b0);
                end
                FMT_ASCII6:
                begin
                    // Three bytes, little endian, make four 6-bit codes.
                    if (st_gcnt >= 2 || fin) begin
                        sh = (st_gcnt >= 2) ? 16 : 8 * int'(st_gcnt);
                        grp_word = {8'h00, st_grp} | (24'(b) << sh);
                        for (int k = 0; k < 4; k++) begin
                            add_char(8'(grp_word[6*k +: 6]) + ASCII6_BIAS, 1'b1,
                                     (k == 3) ? fin : 1'b0, 1'b0);
                        end
                        st_grp  = '0;
                        st_gcnt = '0;
                    end else begin
                        st_grp  = st_grp | (GRP_W'(b) << (8 * int'(st_gcnt)));
                        st_gcnt = st_gcnt + 1'b1;
                    end
                end
                default:
                begin
                    add_char(b, 1'b1, fin, 1'b0);
                end
            endcase
            if (fin) st_mode = MODE_TL;
        end

        if (fresh_chars.size() > 0) begin
            r = fresh_chars.pop_back();
            r.last = 1'b1;
            fresh_chars.push_back(r);
        end
    endtask

    // Drive one input transaction: change inputs at the falling edge, hold them
    // until the rising edge that takes them, then record what it must produce.
    task automatic push_byte(input logic start, input logic [7:0] b, input row_kind_t kind);
        int        gap;
        char_rec_t r;
        @(negedge clk);
        if ($urandom_range(0, 39) == 0) in_steady = !in_steady;
        gap = idle_len(in_steady);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   = 1'b1;
        area_start = start;
        in_byte    = b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent_items++;
        decode_byte(start, b);
        case (kind)
            ROW_CALC:
            begin
                foreach (fresh_chars[i]) chars_due.push_back(fresh_chars[i]);
            end
            ROW_EMPTY:
            begin
                r = '{ch: 8'h00, valid: 1'b0, done: 1'b1, fend: 1'b0, last: 1'b1};
                chars_due.push_back(r);
            end
            ROW_END:
            begin
                r = '{ch: 8'h00, valid: 1'b0, done: 1'b0, fend: 1'b1, last: 1'b1};
                chars_due.push_back(r);
            end
            default:
            begin
            end
        endcase
    endtask

    // Drop valid and wait until every expected result is out and the pipe is empty.
    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (chars_due.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx == CFG_FIELDS_OFFSET) reg_offset = val[OFFSET_W-1:0];
        else if (idx == CFG_AREA_LENGTH) reg_alen = val;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // One area: skipped bytes up to the offset, then fields until the end marker
    // or the area length. A broken area stops inside a field.
    task automatic run_area(input bit broken);
        int          pos;
        int          len;
        int          r;
        logic [7:0]  tl;
        pos = 0;
        while (pos < int'(reg_offset)) begin
            push_byte(pos == 0, 8'($urandom_range(0, 255)), ROW_CALC);
            pos++;
        end
        forever begin
            if (pos >= int'(reg_alen) || $urandom_range(0, 7) == 0) begin
                tl = (pos >= int'(reg_alen)) ? 8'($urandom_range(0, 255)) : END_MARK;
                push_byte(pos == 0, tl, ROW_CALC);
                repeat ($urandom_range(0, 2)) push_byte(1'b0, 8'($urandom_range(0, 255)), ROW_CALC);
                return;
            end
            r = $urandom_range(0, 15);
            if (r < 2)        len = 0;
            else if (r < 14)  len = $urandom_range(1, 6);
            else if (r == 14) len = $urandom_range(7, 20);
            else              len = $urandom_range(40, 63);
            tl = {2'($urandom_range(0, 3)), 6'(len)};
            push_byte(pos == 0, tl, ROW_CALC);
            pos++;
            if (tl == END_MARK) return;
            if (broken && len > 0 && $urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(0, len - 1))
                    push_byte(1'b0, 8'($urandom_range(0, 255)), ROW_CALC);
                return;
            end
            repeat (len) begin
                push_byte(1'b0, 8'($urandom_range(0, 255)), ROW_CALC);
                pos++;
            end
        end
    endtask

    // Receiver side: stall in random bursts, with stretches of no stall at all.
    initial begin
        int hold;
        hold      = 0;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold > 0) begin
                out_stall = 1'b1;
                hold--;
            end else begin
                out_stall = 1'b0;
                if ($urandom_range(0, 39) == 0) out_steady = !out_steady;
                hold = idle_len(out_steady);
            end
        end
    end

    // Compare each result transaction with the oldest expectation.
    always @(posedge clk) begin : check_results
        char_rec_t got;
        char_rec_t want;
        if (rst_n && out_valid && !out_stall) begin
            got = {out_char, char_valid, field_done, fields_end, last};
            if (chars_due.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display({"%0t: result with nothing expected: ",
                              "char %02h valid %b done %b end %b last %b"},
                             $realtime, got.ch, got.valid, got.done, got.fend, got.last);
                mismatches++;
            end else begin
                want = chars_due.pop_front();
                if (got !== want) begin
                    if (mismatches < MAX_REPORTS)
                        $display({"%0t: expected char %02h valid %b done %b end %b last %b, ",
                                  "got char %02h valid %b done %b end %b last %b"},
                                 $realtime, want.ch, want.valid, want.done, want.fend,
                                 want.last, got.ch, got.valid, got.done, got.fend, got.last);
                    mismatches++;
                end
            end
        end
    end

    // Hard stop if the block hangs; far beyond the slowest correct run.
    initial begin
        #25ms;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int                    base;
        int                    target;
        int                    r;
        logic [OFFSET_W-1:0]   new_off;
        logic [CFG_DATA_W-1:0] new_len;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_byte    = 8'h00;
        area_start = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_FIELDS_OFFSET;
        cfg_data   = '0;

        reg_offset = FIELDS_OFFSET_RST;
        reg_alen   = AREA_LENGTH_RST;
        st_mode    = MODE_IDLE;
        st_pos     = '0;
        st_kind    = FMT_BIN;
        st_left    = '0;
        st_grp     = '0;
        st_gcnt    = '0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part.
        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) begin
                wait_idle();
                write_reg(plan[i].idx, plan[i].val);
            end else begin
                push_byte(plan[i].start, plan[i].val[7:0], plan[i].kind);
            end
        end
        foreach (plan_tail[i]) push_byte(plan_tail[i].start, plan_tail[i].val[7:0], plan_tail[i].kind);

        // Random part: several register settings, the extremes among them.
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: begin new_off = 8'd0;   new_len = 11'd2040; end
                1: begin new_off = 8'd2;   new_len = 11'd24;   end
                2: begin new_off = 8'd5;   new_len = 11'd3;    end  // offset past the length
                3: begin new_off = 8'd20;  new_len = 11'd64;   end
                4: begin new_off = 8'd1;   new_len = 11'd0;    end
                5: begin new_off = 8'($urandom_range(0, 12)); new_len = 11'($urandom_range(0, 2040)); end
                default: begin new_off = 8'($urandom_range(0, 12)); new_len = 11'($urandom_range(0, 80)); end
            endcase
            wait_idle();
            if ($urandom_range(0, 1) == 0) begin
                write_reg(CFG_FIELDS_OFFSET, CFG_DATA_W'(new_off));
                write_reg(CFG_AREA_LENGTH, new_len);
            end else begin
                write_reg(CFG_AREA_LENGTH, new_len);
                write_reg(CFG_FIELDS_OFFSET, CFG_DATA_W'(new_off));
            end
            if ($urandom_range(0, 2) == 0) write_reg(CFG_IDX_SPARE, 11'($urandom_range(0, 2047)));

            target = PHASE_ITEMS;
            base   = sent_items;
            do begin
                r = $urandom_range(0, 99);
                if (r < 10)
                    push_byte($urandom_range(0, 7) == 0, 8'($urandom_range(0, 255)), ROW_CALC);
                else
                    run_area(r < 25);
            end while (sent_items - base < target);
        end

        // Drain, then give late results time to show up.
        @(negedge clk);
        in_valid = 1'b0;
        while (chars_due.size() != 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (chars_due.size() != 0) mismatches += chars_due.size();

        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
